FILE: design/assert_macros.svh
// Assertion macros for the RTL design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/mjh_pkg.sv
// Package with constants and types of the minimum-jerk homing step.
package mjh_pkg;
    localparam int NUM_JOINTS = 7;
    localparam int MAXJ = 7;
    localparam int POS_W = 24;
    localparam int TICK_W = 20;
    localparam int Q_W = 25;
    localparam int JIDX_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam logic [24:0] ONE_Q24 = 25'd16777216;
    localparam logic [24:0] THRESH_LSB = 25'd5243;
    localparam logic [24:0] STEP_LIM = 25'd104858;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TICKS = 3'd7;
    localparam int IN_W = POS_W * MAXJ;
    localparam int OUT_W = ((POS_W * MAXJ + 1 + 7) / 8) * 8;
    typedef logic signed [POS_W-1:0] pos_t;
endpackage

FILE: design/min_jerk_joint_homing_step.sv
// Minimum-jerk homing step: one command set per servo tick over a divider and a shared multiplier.
// The result is offered after a restoring bit-serial divider for s = t/move_ticks, a step that
// loads s, multiplies for s^2..s^5, a step that forms and clamps lambda, then one multiply
// per joint on the single shared 25x25 multiplier. The result then waits until it is taken,
// and the input is ready again in the cycle after that transfer.
// The input is not ready while a tick is in flight or while the result waits to be taken.
// All commands of one tick leave together in one transfer with the all_reached flag.
`include "assert_macros.svh"
module min_jerk_joint_homing_step (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // joint_0_position .. joint_6_position, 24 bits each from the lowest bits up
    input  logic [mjh_pkg::IN_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // joint_0_command .. joint_6_command (24 bits each), all_reached, zero fill
    output logic [mjh_pkg::OUT_W-1:0] m_tdata,
    input  logic cfg_we,
    input  logic [mjh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mjh_pkg::POS_W-1:0] cfg_wdata
);
    import mjh_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_POW, S_LAM, S_JNT, S_OUT} state_t;

    state_t state_reg;
    pos_t home_reg [MAXJ];
    logic [TICK_W-1:0] move_reg, tick_reg, m_reg;
    pos_t cur_reg [MAXJ];
    pos_t cmd_reg [MAXJ];
    logic [MAXJ-1:0] near_reg;
    logic [5:0] cnt_reg;
    logic [44:0] rem_reg;
    logic [24:0] quo_reg, s_reg, pw_reg;
    logic [24:0] p_reg [4];
    logic [24:0] lam_reg;
    logic [JIDX_W-1:0] j_reg;

    // Shared multiplier.
    logic [24:0] mul_a, mul_b;
    logic [49:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [TICK_W-1:0] m_eff, t_inc;
    logic [TICK_W:0] t_sum;
    assign m_eff = (move_reg == '0) ? TICK_W'(1) : move_reg;
    assign t_sum = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign t_inc = (t_sum > {1'b0, m_eff}) ? m_eff : t_sum[TICK_W-1:0];

    // Divider step.
    logic [44:0] rem_sh;
    logic [45:0] rem_try;
    assign rem_sh = rem_reg;
    assign rem_try = {1'b0, rem_sh} - {26'd0, m_reg};

    // Joint datapath.
    logic signed [Q_W-1:0] err;
    logic [Q_W-1:0] mag;
    logic [24:0] step_mag;
    logic signed [Q_W:0] cmd_w;
    pos_t cmd_sat;
    pos_t cur_j, home_j;
    assign cur_j = cur_reg[j_reg];
    assign home_j = home_reg[j_reg];
    assign err = Q_W'(home_j) - Q_W'(cur_j);
    assign mag = err[Q_W-1] ? Q_W'(-err) : err;
    assign step_mag = (mul_p[48:24] > STEP_LIM) ? STEP_LIM : mul_p[48:24];
    always_comb begin
        cmd_w = err[Q_W-1] ? ((Q_W+1)'(cur_j) - (Q_W+1)'(step_mag))
                           : ((Q_W+1)'(cur_j) + (Q_W+1)'(step_mag));
        if (cmd_w > 26'sd8388607) cmd_sat = 24'sh7FFFFF;
        else if (cmd_w < -26'sd8388608) cmd_sat = 24'sh800000;
        else cmd_sat = cmd_w[POS_W-1:0];
    end

    // lambda = 10 s^3 - 15 s^4 + 6 s^5, then clamped to [0, 1].
    logic signed [30:0] lam_w;
    assign lam_w = 31'sd10 * $signed({6'd0, p_reg[1]}) - 31'sd15 * $signed({6'd0, p_reg[2]})
                 + 31'sd6 * $signed({6'd0, p_reg[3]});

    always_comb begin
        mul_a = mag;
        mul_b = lam_reg;
        if (state_reg == S_POW) begin
            mul_a = pw_reg;
            mul_b = s_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < MAXJ; i++) home_reg[i] <= '0;
            move_reg <= TICK_W'(5000);
            tick_reg <= '0;
            cnt_reg <= '0;
            j_reg <= '0;
            near_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_MOVE_TICKS) move_reg <= cfg_wdata[TICK_W-1:0];
                else home_reg[cfg_index] <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = 0; i < MAXJ; i++)
                            cur_reg[i] <= s_tdata[i*POS_W +: POS_W];
                        tick_reg <= t_inc;
                        m_reg <= m_eff;
                        rem_reg <= 45'(t_inc);
                        quo_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle of (t << 24) / m.
                    if (rem_try[45]) begin
                        quo_reg <= {quo_reg[23:0], 1'b0};
                        rem_reg <= {rem_sh[43:0], 1'b0};
                    end else begin
                        quo_reg <= {quo_reg[23:0], 1'b1};
                        rem_reg <= {rem_try[43:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd24) begin
                        state_reg <= S_POW;
                        cnt_reg <= '0;
                    end
                end
                S_POW: begin
                    if (cnt_reg == '0) begin
                        s_reg <= quo_reg;
                        pw_reg <= quo_reg;
                        cnt_reg <= 6'd1;
                    end else begin
                        p_reg[cnt_reg[1:0] - 2'd1] <= mul_p[48:24];
                        pw_reg <= mul_p[48:24];
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd4) state_reg <= S_LAM;
                    end
                end
                S_LAM: begin
                    if (lam_w < 0) lam_reg <= '0;
                    else if (lam_w > $signed({6'd0, ONE_Q24})) lam_reg <= ONE_Q24;
                    else lam_reg <= lam_w[24:0];
                    j_reg <= '0;
                    state_reg <= S_JNT;
                end
                S_JNT: begin
                    if (mag <= THRESH_LSB) begin
                        near_reg[j_reg] <= 1'b1;
                        cmd_reg[j_reg] <= home_j;
                    end else begin
                        near_reg[j_reg] <= 1'b0;
                        cmd_reg[j_reg] <= cmd_sat;
                    end
                    j_reg <= j_reg + JIDX_W'(1);
                    if (j_reg == JIDX_W'(NUM_JOINTS - 1)) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The division step reads the remainder before the first shift, so the dividend
    // starts unshifted and each cycle compares, then shifts in a zero.
    // Quotient width: t/m <= 1, so 25 bits cover 2^24.

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < MAXJ; i++)
            m_tdata[i*POS_W +: POS_W] = (i < NUM_JOINTS) ? cmd_reg[i] : '0;
        m_tdata[MAXJ*POS_W] = &near_reg[NUM_JOINTS-1:0];
    end

    `ASSERT_IMPL(a_no_both, aclk, aresetn, 1'b1, !(s_tready && m_tvalid), "ready while result pending")
    `ASSERT_IMPL(a_tick_le, aclk, aresetn, state_reg == S_OUT, tick_reg <= m_reg, "tick beyond move length")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result lost")
endmodule

FILE: tb/tb_min_jerk_joint_homing_step.sv
// Self-checking testbench for the minimum-jerk homing step block.
`default_nettype none

module tb_min_jerk_joint_homing_step;
    timeunit 1ns;
    timeprecision 1ps;
    import mjh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int REACHED_BIT = POS_W * MAXJ;
    localparam longint Q_LO = -8388608;
    localparam longint Q_HI = 8388607;

    typedef struct {
        pos_t cmd[MAXJ];
        bit reached;
    } tick_result_t;

    // Keeps its own copy of the registers and the tick counter and predicts each command set.
    class homing_scoreboard;
        longint home[MAXJ];
        longint unsigned move_len;
        longint unsigned ticks;
        tick_result_t pending_cmds[$];
        int errors;

        function new();
            foreach (home[j]) home[j] = 0;
            move_len = 5000;
            ticks = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
            pos_t p;
            p = val;
            if (idx == REG_MOVE_TICKS) move_len = val[TICK_W-1:0];
            else home[idx] = p;
        endfunction

        function void note_input(logic [IN_W-1:0] d);
            longint unsigned m, t, s, s2, s3, s4, s5;
            longint lam, cur, err, mag, stp, cmd;
            pos_t p;
            int hits;
            tick_result_t e;
            m = (move_len == 0) ? 1 : move_len;
            t = ticks + 1;
            if (t > m) t = m;
            ticks = t;
            s = (t << 24) / m;
            s2 = (s * s) >> 24;
            s3 = (s2 * s) >> 24;
            s4 = (s3 * s) >> 24;
            s5 = (s4 * s) >> 24;
            lam = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
            if (lam < 0) lam = 0;
            if (lam > 64'd16777216) lam = 64'd16777216;
            hits = 0;
            for (int j = 0; j < MAXJ; j++) begin
                if (j >= NUM_JOINTS) begin
                    e.cmd[j] = '0;
                    continue;
                end
                p = d[j*POS_W +: POS_W];
                cur = p;
                err = home[j] - cur;
                mag = (err < 0) ? -err : err;
                if (mag <= longint'(THRESH_LSB)) begin
                    hits++;
                    cmd = home[j];
                end else begin
                    stp = (mag * lam) >>> 24;
                    if (stp > longint'(STEP_LIM)) stp = STEP_LIM;
                    if (err < 0) stp = -stp;
                    cmd = cur + stp;
                    if (cmd > Q_HI) cmd = Q_HI;
                    if (cmd < Q_LO) cmd = Q_LO;
                end
                e.cmd[j] = cmd[POS_W-1:0];
            end
            e.reached = (hits == NUM_JOINTS);
            pending_cmds.push_back(e);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] d);
            tick_result_t e;
            pos_t got;
            if (pending_cmds.size() == 0) begin
                report("command set arrived with none expected");
                return;
            end
            e = pending_cmds.pop_front();
            for (int j = 0; j < MAXJ; j++) begin
                got = d[j*POS_W +: POS_W];
                if (got !== e.cmd[j])
                    report($sformatf("joint %0d command %0d, expected %0d", j, got, e.cmd[j]));
            end
            if (d[REACHED_BIT] !== e.reached)
                report($sformatf("all_reached %b, expected %b", d[REACHED_BIT], e.reached));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0] cfg_wdata = '0;

    homing_scoreboard sb = new();
    bit quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    min_jerk_joint_homing_step uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // Result side: random stalls, checked on every completed transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("min_jerk_joint_homing_step verification failed");
            $finish;
        end
    end

    task send_tick(logic [IN_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d);
    endtask

    task wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_we high so that back-to-back writes do not toggle it within a step.
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task end_writes();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [POS_W-1:0] rand_home();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return $urandom_range(0, 400000) - 200000;
            default: return $urandom;
        endcase
    endfunction

    // Measured positions mostly around the target so every branch of the step is reached.
    function automatic logic [POS_W-1:0] rand_pos(longint h);
        longint v;
        case ($urandom_range(0, 9))
            0: v = h + longint'($urandom_range(0, 10486)) - 5243;
            1: v = h + ($urandom_range(0, 1) ? 5243 : -5243);
            2: v = h + ($urandom_range(0, 1) ? 5244 : -5244);
            3, 4: v = h + longint'($urandom_range(0, 60000)) - 30000;
            5, 6: v = h + longint'($urandom_range(0, 600000)) - 300000;
            7: v = $urandom_range(0, 1) ? Q_HI : Q_LO;
            default: v = longint'(pos_t'($urandom));
        endcase
        if (v > Q_HI) v = Q_HI;
        if (v < Q_LO) v = Q_LO;
        return v[POS_W-1:0];
    endfunction

    function automatic logic [IN_W-1:0] rand_tick();
        logic [IN_W-1:0] d;
        for (int j = 0; j < MAXJ; j++) d[j*POS_W +: POS_W] = rand_pos(sb.home[j]);
        return d;
    endfunction

    function automatic logic [IN_W-1:0] same_pos(logic [POS_W-1:0] p);
        logic [IN_W-1:0] d;
        for (int j = 0; j < MAXJ; j++) d[j*POS_W +: POS_W] = p;
        return d;
    endfunction

    initial begin
        logic [IN_W-1:0] d;
        logic [POS_W-1:0] move_settings[10];
        move_settings = '{24'd17, 24'd60, 24'd200, 24'd3, 24'd1, 24'd0, 24'hFFFFF,
                          24'd5000, 24'hF00010, 24'd2};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: a few ticks at reset settings, then target extremes.
        send_tick(same_pos(24'h000000));
        send_tick(same_pos(24'h7FFFFF));
        send_tick(same_pos(24'h800000));
        wait_idle();
        write_reg(0, 24'h7FFFFF);
        write_reg(1, 24'h800000);
        write_reg(2, 24'h000000);
        write_reg(3, 24'd5243);
        write_reg(4, 24'hFFEB85);
        write_reg(5, 24'h123456);
        write_reg(6, 24'hEDCBA9);
        write_reg(REG_MOVE_TICKS, 24'd6);
        end_writes();
        send_tick(same_pos(24'h800000));
        send_tick(same_pos(24'h7FFFFF));
        send_tick(same_pos(24'h000000));
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < MAXJ; j++)
                d[j*POS_W +: POS_W] = sb.home[j] + (k[0] ? 5243 : -5244) * (k[1] ? 1 : -1);
            send_tick(d);
        end
        for (int j = 0; j < MAXJ; j++) d[j*POS_W +: POS_W] = sb.home[j];
        send_tick(d);
        for (int k = 0; k < 8; k++) send_tick(rand_tick());

        // Random part: each phase retargets the joints and changes the move length.
        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            for (int j = 0; j < MAXJ; j++) write_reg(j, rand_home());
            write_reg(REG_MOVE_TICKS, move_settings[ph]);
            end_writes();
            quiet = (ph == 4);
            for (int k = 0; k < 125; k++) begin
                if (ph == 2 && k == 60) wait_idle();
                send_tick(rand_tick());
            end
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("min_jerk_joint_homing_step verification clean");
        end else begin
            $display("min_jerk_joint_homing_step verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: min_jerk_joint_homing_step.f
+incdir+design
design/mjh_pkg.sv
design/min_jerk_joint_homing_step.sv
tb/tb_min_jerk_joint_homing_step.sv
